### hw/rtl/spau_pkg.sv
// Shared types, codes and field helpers for the pointer-to-shared arithmetic unit.
// No dependencies; used by spau_div and shared_pointer_arith_unit_top.
package spau_pkg;

	localparam int unsigned DW = 64;

	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_SUB  = 2'd1;
	localparam logic [1:0] ACT_DIFF = 2'd2;
	localparam logic [1:0] ACT_CMP  = 2'd3;

	localparam logic [2:0] CMP_EQ = 3'd0;
	localparam logic [2:0] CMP_NE = 3'd1;
	localparam logic [2:0] CMP_LT = 3'd2;
	localparam logic [2:0] CMP_GT = 3'd3;
	localparam logic [2:0] CMP_LE = 3'd4;
	localparam logic [2:0] CMP_GE = 3'd5;

	localparam logic [2:0] REG_PHASE_BITS   = 3'd0;
	localparam logic [2:0] REG_THREAD_BITS  = 3'd1;
	localparam logic [2:0] REG_ADDR_BITS    = 3'd2;
	localparam logic [2:0] REG_ADDR_FIRST   = 3'd3;
	localparam logic [2:0] REG_BLOCK_SIZE   = 3'd4;
	localparam logic [2:0] REG_THREAD_COUNT = 3'd5;
	localparam logic [2:0] REG_ELEM_SIZE    = 3'd6;
	localparam logic [2:0] REG_ARRAY_DIM    = 3'd7;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	typedef struct packed {
		logic [1:0]         action;
		logic [DW-1:0]      pointer_a;
		logic [DW-1:0]      pointer_b;
		logic signed [DW-1:0] index_value;
		logic [2:0]         compare_op;
	} req_t;

	typedef struct packed {
		logic [DW-1:0]        result_pointer;
		logic signed [DW-1:0] difference;
		logic                 compare_true;
	} rsp_t;

	// unpacked pointer fields
	typedef struct packed {
		logic [DW-1:0] ph;
		logic [DW-1:0] th;
		logic [DW-1:0] ad;
	} fld_t;

	// compare flags carried down the front stages
	typedef struct packed {
		logic flip;
		logic bad;
		logic eqop;
		logic eq;
		logic ltad;
		logic thlt;
		logic theq;
		logic phlt;
	} cmpf_t;

	// sideband that rides through the dividers
	typedef struct packed {
		logic [1:0]    act;
		logic          neg;
		logic          cmp;
		logic [DW-1:0] ad;
		logic [DW-1:0] ph;
		logic [DW-1:0] th;
		logic [DW-1:0] aux;
		logic [DW-1:0] ext;
	} pl_t;

	function automatic logic [6:0] cap_w(input logic [6:0] w);
		logic [6:0] r;
		r = (w > 7'd64) ? 7'd64 : w;
		return r;
	endfunction

	function automatic logic [DW-1:0] lmask(input logic [6:0] w);
		logic [DW-1:0] m;
		if (w[6]) begin
			m = '1;
		end else begin
			m = (64'd1 << w[5:0]) - 64'd1;
		end
		return m;
	endfunction

	function automatic logic [DW-1:0] get_field(input logic [DW-1:0] x, input logic [7:0] pos,
		input logic [6:0] w);
		logic [DW-1:0] r;
		if (pos[7:6] != 2'd0) begin
			r = '0;
		end else begin
			r = (x >> pos[5:0]) & lmask(w);
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] put_field(input logic [DW-1:0] v, input logic [7:0] pos,
		input logic [6:0] w);
		logic [DW-1:0] r;
		if (pos[7:6] != 2'd0) begin
			r = '0;
		end else begin
			r = (v & lmask(w)) << pos[5:0];
		end
		return r;
	endfunction

	function automatic fld_t unpack(input logic [DW-1:0] p, input logic [5:0] pb,
		input logic [5:0] tb, input logic [6:0] ab, input logic af);
		fld_t f;
		logic [6:0] pw, tw, aw;
		pw = {1'b0, pb};
		tw = {1'b0, tb};
		aw = cap_w(ab);
		if (af) begin
			f.ph = get_field(p, 8'd0, pw);
			f.th = get_field(p, 8'(pw), tw);
			f.ad = get_field(p, 8'(pw) + 8'(tw), aw);
		end else begin
			f.ad = get_field(p, 8'd0, aw);
			f.th = get_field(p, 8'(aw), tw);
			f.ph = get_field(p, 8'(aw) + 8'(tw), pw);
		end
		return f;
	endfunction

	function automatic logic [DW-1:0] pack(input fld_t f, input logic [5:0] pb,
		input logic [5:0] tb, input logic [6:0] ab, input logic af);
		logic [DW-1:0] r;
		logic [6:0] pw, tw, aw;
		pw = {1'b0, pb};
		tw = {1'b0, tb};
		aw = cap_w(ab);
		if (af) begin
			r = put_field(f.ph, 8'd0, pw) | put_field(f.th, 8'(pw), tw)
				| put_field(f.ad, 8'(pw) + 8'(tw), aw);
		end else begin
			r = put_field(f.ad, 8'd0, aw) | put_field(f.th, 8'(aw), tw)
				| put_field(f.ph, 8'(aw) + 8'(tw), pw);
		end
		return r;
	endfunction

endpackage

### hw/rtl/spau_div.sv
// Pipelined unsigned 64-bit divider, one quotient bit per stage, with sideband.
// Depends on spau_pkg (DW).
module spau_div #(
	parameter int unsigned SW = 324
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic [spau_pkg::DW-1:0] in_num,
	input  logic [spau_pkg::DW-1:0] in_den,
	input  logic [SW-1:0]           in_side,
	output logic                    out_vld,
	output logic [spau_pkg::DW-1:0] out_quo,
	output logic [spau_pkg::DW-1:0] out_rem,
	output logic [SW-1:0]           out_side
);
	import spau_pkg::*;

	logic          vld_s  [1:DW];
	logic [DW-1:0] rem_s  [1:DW];
	logic [DW-1:0] nq_s   [1:DW];
	logic [DW-1:0] den_s  [1:DW];
	logic [SW-1:0] side_s [1:DW];

	for (genvar gi = 0; gi < DW; gi++) begin : g_stage
		logic          cur_v;
		logic [DW-1:0] cur_rem, cur_nq, cur_den;
		logic [SW-1:0] cur_side;
		logic [DW:0]   sh;
		logic          ge;

		if (gi == 0) begin : g_in
			assign cur_v    = in_vld;
			assign cur_rem  = '0;
			assign cur_nq   = in_num;
			assign cur_den  = in_den;
			assign cur_side = in_side;
		end else begin : g_mid
			assign cur_v    = vld_s[gi];
			assign cur_rem  = rem_s[gi];
			assign cur_nq   = nq_s[gi];
			assign cur_den  = den_s[gi];
			assign cur_side = side_s[gi];
		end

		assign sh = {cur_rem, cur_nq[DW-1]};
		assign ge = (sh >= {1'b0, cur_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi+1] <= 1'b0;
			end else begin
				vld_s[gi+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[gi+1]  <= ge ? DW'(sh - {1'b0, cur_den}) : sh[DW-1:0];
			nq_s[gi+1]   <= {cur_nq[DW-2:0], ge};
			den_s[gi+1]  <= cur_den;
			side_s[gi+1] <= cur_side;
		end
	end

	assign out_vld  = vld_s[DW];
	assign out_quo  = nq_s[DW];
	assign out_rem  = rem_s[DW];
	assign out_side = side_s[DW];

	a_lat_vld: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##64 out_vld) else $error("divider lost a request");
	a_lat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_vld |-> ##64 !out_vld) else $error("divider invented a request");
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && den_s[DW] != '0) |-> (out_rem < den_s[DW]))
		else $error("divider remainder not below divisor");

endmodule

### hw/rtl/shared_pointer_arith_unit_top.sv
// Top level of the pointer-to-shared arithmetic unit (block-cyclic layout).
// Depends on spau_pkg and spau_div.
// Pipeline: a request taken at a clock edge shows its result on rsp with done high
//   after 4 front stages, 64-stage divider, 5 middle stages, 64-stage divider, 4 back stages.
// Throughput: one request per cycle; busy is always low, and done lasts one cycle.
// The two bit-per-stage dividers set the depth; the receiver cannot stall the pipe.
// Reset (arst_n low, asynchronous) clears all valid bits and loads register defaults.
module shared_pointer_arith_unit_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  spau_pkg::req_t                req,
	output logic                          done,
	output spau_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [spau_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [spau_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import spau_pkg::*;

	// ---------------- configuration registers ----------------
	logic [5:0]  phase_bits_q, thread_bits_q;
	logic [6:0]  addr_bits_q;
	logic        addr_first_q;
	logic [19:0] block_size_q;
	logic [10:0] thread_count_q;
	logic [15:0] elem_size_q, array_dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_bits_q   <= 6'd20;
			thread_bits_q  <= 6'd10;
			addr_bits_q    <= 7'd34;
			addr_first_q   <= 1'b0;
			block_size_q   <= 20'd1;
			thread_count_q <= 11'd1;
			elem_size_q    <= 16'd1;
			array_dim_q    <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PHASE_BITS:   phase_bits_q   <= cfg_wdata[5:0];
				REG_THREAD_BITS:  thread_bits_q  <= cfg_wdata[5:0];
				REG_ADDR_BITS:    addr_bits_q    <= cfg_wdata[6:0];
				REG_ADDR_FIRST:   addr_first_q   <= cfg_wdata[0];
				REG_BLOCK_SIZE:   block_size_q   <= cfg_wdata[19:0];
				REG_THREAD_COUNT: thread_count_q <= cfg_wdata[10:0];
				REG_ELEM_SIZE:    elem_size_q    <= cfg_wdata[15:0];
				REG_ARRAY_DIM:    array_dim_q    <= cfg_wdata[15:0];
			endcase
		end
	end

	// zero thread count, element size and array dimension behave as one
	logic [10:0] tc1;
	logic [15:0] es1, adim1;
	logic [19:0] bs;
	logic        bs_zero;
	logic [30:0] grp;   // elements per full round of blocks over all threads
	assign tc1     = (thread_count_q == '0) ? 11'd1 : thread_count_q;
	assign es1     = (elem_size_q == '0) ? 16'd1 : elem_size_q;
	assign adim1   = (array_dim_q == '0) ? 16'd1 : array_dim_q;
	assign bs      = block_size_q;
	assign bs_zero = (bs == '0);
	assign grp     = 31'(tc1) * 31'(bs);

	// Fully pipelined: a request is taken every cycle.
	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// ---------------- stage 1: unpack, swap for gt/le ----------------
	logic        v_s1;
	logic [1:0]  act_s1;
	fld_t        fa_s1, fb_s1;
	logic [DW-1:0] idx_s1;
	logic        flip_s1, bad_s1, eqop_s1;

	logic swap;
	logic [DW-1:0] pa, pb;
	assign swap = (req.action == ACT_CMP)
		&& (req.compare_op == CMP_GT || req.compare_op == CMP_LE);
	assign pa = swap ? req.pointer_b : req.pointer_a;
	assign pb = swap ? req.pointer_a : req.pointer_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		act_s1  <= req.action;
		fa_s1   <= unpack(pa, phase_bits_q, thread_bits_q, addr_bits_q, addr_first_q);
		fb_s1   <= unpack(pb, phase_bits_q, thread_bits_q, addr_bits_q, addr_first_q);
		idx_s1  <= req.index_value;
		flip_s1 <= (req.compare_op == CMP_NE) || (req.compare_op == CMP_LE)
			|| (req.compare_op == CMP_GE);
		bad_s1  <= (req.compare_op > CMP_GE);
		eqop_s1 <= (req.compare_op == CMP_EQ) || (req.compare_op == CMP_NE);
	end

	// ---------------- stage 2: scale index, field differences ----------------
	logic        v_s2;
	logic [1:0]  act_s2;
	fld_t        fa_s2;
	cmpf_t       cf_s2;
	logic [DW-1:0] idxm_s2, thb_s2, abd_s2, pd_s2, thd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s2       <= act_s1;
		fa_s2        <= fa_s1;
		idxm_s2      <= idx_s1 * DW'(adim1);
		thb_s2       <= fa_s1.th * DW'(bs);
		abd_s2       <= fa_s1.ad - fb_s1.ad;
		pd_s2        <= fa_s1.ph - fb_s1.ph;
		thd_s2       <= fa_s1.th - fb_s1.th;
		cf_s2.flip   <= flip_s1;
		cf_s2.bad    <= bad_s1;
		cf_s2.eqop   <= eqop_s1;
		cf_s2.eq     <= (fa_s1.ad == fb_s1.ad) && (fa_s1.th == fb_s1.th);
		cf_s2.ltad   <= fa_s1.ad < fb_s1.ad;
		cf_s2.thlt   <= fa_s1.th < fb_s1.th;
		cf_s2.theq   <= fa_s1.th == fb_s1.th;
		cf_s2.phlt   <= fa_s1.ph < fb_s1.ph;
	end

	// ---------------- stage 3: linear element position, byte scaling ----------------
	logic        v_s3;
	logic [1:0]  act_s3;
	fld_t        fa_s3;
	cmpf_t       cf_s3;
	logic [DW-1:0] t_s3, ies_s3, abd_s3, pbd_s3, pd_s3, thd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		act_s3 <= act_s2;
		fa_s3  <= fa_s2;
		cf_s3  <= cf_s2;
		if (act_s2 == ACT_SUB) begin
			t_s3 <= thb_s2 + fa_s2.ph - idxm_s2;
		end else begin
			t_s3 <= thb_s2 + fa_s2.ph + idxm_s2;
		end
		ies_s3 <= idxm_s2 * DW'(es1);
		abd_s3 <= abd_s2;
		pbd_s3 <= pd_s2 * DW'(es1);
		pd_s3  <= pd_s2;
		thd_s3 <= thd_s2;
	end

	// ---------------- stage 4: compare outcome, first divider operands ----------------
	logic        v_s4;
	logic [DW-1:0] num_s4, den_s4;
	pl_t         pl_s4;

	logic slt_ab, ord, cmp_r;
	assign slt_ab = (abd_s3 ^ {1'b1, {(DW-1){1'b0}}}) < (pbd_s3 ^ {1'b1, {(DW-1){1'b0}}});

	always_comb begin
		// block, then thread, then phase
		if (bs_zero) begin
			ord = cf_s3.ltad;
		end else if (slt_ab) begin
			ord = 1'b1;
		end else if (abd_s3 != pbd_s3) begin
			ord = 1'b0;
		end else if (cf_s3.thlt) begin
			ord = 1'b1;
		end else if (!cf_s3.theq) begin
			ord = 1'b0;
		end else begin
			ord = cf_s3.phlt;
		end
		cmp_r = cf_s3.bad ? 1'b0 : ((cf_s3.eqop ? cf_s3.eq : ord) ^ cf_s3.flip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pl_s4.act <= act_s3;
		pl_s4.cmp <= cmp_r;
		pl_s4.ext <= '0;
		if (act_s3 == ACT_DIFF) begin
			// byte distance over element size
			pl_s4.neg <= abd_s3[DW-1];
			num_s4    <= abd_s3[DW-1] ? (DW'(0) - abd_s3) : abd_s3;
			den_s4    <= DW'(es1);
			pl_s4.ad  <= fa_s3.ad;
			pl_s4.ph  <= pd_s3;
			pl_s4.th  <= thd_s3;
			pl_s4.aux <= '0;
		end else begin
			// floor split of the element position over one round of blocks
			pl_s4.neg <= t_s3[DW-1];
			num_s4    <= t_s3[DW-1] ? (DW'(0) - t_s3) : t_s3;
			den_s4    <= DW'(grp);
			pl_s4.ad  <= fa_s3.ad;
			pl_s4.ph  <= fa_s3.ph;
			pl_s4.th  <= fa_s3.th;
			pl_s4.aux <= (act_s3 == ACT_SUB) ? (DW'(0) - ies_s3) : ies_s3;
		end
	end

	// ---------------- first divider ----------------
	logic          da_vld;
	logic [DW-1:0] da_quo, da_rem;
	logic [$bits(pl_t)-1:0] da_side;

	spau_div #(
		.SW($bits(pl_t))
	) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s4),
		.in_num   (num_s4),
		.in_den   (den_s4),
		.in_side  (pl_s4),
		.out_vld  (da_vld),
		.out_quo  (da_quo),
		.out_rem  (da_rem),
		.out_side (da_side)
	);

	pl_t da_pl;
	assign da_pl = pl_t'(da_side);

	// ---------------- stage 5: floor correction / sign of quotient ----------------
	logic        v_s5;
	pl_t         pl_s5;
	logic [DW-1:0] qv_s5, rv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= da_vld;
		end
	end

	always_ff @(posedge clk) begin
		pl_s5 <= da_pl;
		if (da_pl.act == ACT_DIFF) begin
			qv_s5 <= da_pl.neg ? (DW'(0) - da_quo) : da_quo;
			rv_s5 <= da_rem;
		end else if (da_pl.neg && da_rem != '0) begin
			// negative position with a remainder: round the quotient toward minus infinity
			qv_s5 <= DW'(0) - (da_quo + DW'(1));
			rv_s5 <= DW'(grp) - da_rem;
		end else begin
			qv_s5 <= da_pl.neg ? (DW'(0) - da_quo) : da_quo;
			rv_s5 <= da_rem;
		end
	end

	// ---------------- stage 6: block multiples ----------------
	logic        v_s6;
	pl_t         pl_s6;
	pl_t         pl_s5_ext;
	logic [DW-1:0] qv_s6, rv_s6, s_s6, tdb_s6;

	// quotient times block size rides in ext
	always_comb begin
		pl_s5_ext     = pl_s5;
		pl_s5_ext.ext = qv_s5 * DW'(bs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		pl_s6     <= pl_s5_ext;
		qv_s6     <= qv_s5;
		rv_s6     <= rv_s5;
		s_s6      <= qv_s5 - pl_s5.ph;
		tdb_s6    <= pl_s5.th * DW'(bs);
	end

	// ---------------- stage 7: scale by thread count ----------------
	logic        v_s7;
	pl_t         pl_s7;
	logic [DW-1:0] qv_s7, rv_s7, st_s7, tdb_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		pl_s7  <= pl_s6;
		qv_s7  <= qv_s6;
		rv_s7  <= rv_s6;
		st_s7  <= s_s6 * DW'(tc1);
		tdb_s7 <= tdb_s6;
	end

	// ---------------- stage 8: element difference before array scaling ----------------
	logic        v_s8;
	pl_t         pl_s8;
	logic [DW-1:0] res_s8, rv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		pl_s8  <= pl_s7;
		rv_s8  <= rv_s7;
		res_s8 <= bs_zero ? qv_s7 : (st_s7 + tdb_s7 + pl_s7.ph);
	end

	// ---------------- stage 9: second divider operands ----------------
	logic        v_s9;
	pl_t         pl_s9;
	pl_t         pl_s8_nx;
	logic [DW-1:0] num_s9, den_s9;

	// sign of the difference; the thread/phase split is never negative
	always_comb begin
		pl_s8_nx     = pl_s8;
		pl_s8_nx.neg = (pl_s8.act == ACT_DIFF) && res_s8[DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		pl_s9 <= pl_s8_nx;
		if (pl_s8.act == ACT_DIFF) begin
			num_s9    <= res_s8[DW-1] ? (DW'(0) - res_s8) : res_s8;
			den_s9    <= DW'(adim1);
		end else begin
			// remainder splits into thread (quotient) and phase (remainder)
			num_s9    <= rv_s8;
			den_s9    <= DW'(bs);
		end
	end

	// ---------------- second divider ----------------
	logic          db_vld;
	logic [DW-1:0] db_quo, db_rem;
	logic [$bits(pl_t)-1:0] db_side;

	spau_div #(
		.SW($bits(pl_t))
	) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s9),
		.in_num   (num_s9),
		.in_den   (den_s9),
		.in_side  (pl_s9),
		.out_vld  (db_vld),
		.out_quo  (db_quo),
		.out_rem  (db_rem),
		.out_side (db_side)
	);

	pl_t db_pl;
	assign db_pl = pl_t'(db_side);

	// ---------------- stage 10: new fields, element advance ----------------
	logic        v_s10;
	pl_t         pl_s10;
	logic [DW-1:0] val_s10, nph_s10, nth_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= db_vld;
		end
	end

	always_ff @(posedge clk) begin
		pl_s10 <= db_pl;
		if (db_pl.act == ACT_DIFF) begin
			val_s10 <= db_pl.neg ? (DW'(0) - db_quo) : db_quo;
		end else begin
			val_s10 <= (db_rem - db_pl.ph) + db_pl.ext;
		end
		nph_s10 <= bs_zero ? db_pl.ph : db_rem;
		nth_s10 <= bs_zero ? db_pl.th : db_quo;
	end

	// ---------------- stage 11: bytes of address advance ----------------
	logic        v_s11;
	pl_t         pl_s11;
	logic [DW-1:0] val_s11, nph_s11, nth_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		pl_s11  <= pl_s10;
		nph_s11 <= nph_s10;
		nth_s11 <= nth_s10;
		if (pl_s10.act == ACT_DIFF) begin
			val_s11 <= val_s10;
		end else if (bs_zero) begin
			val_s11 <= pl_s10.aux;
		end else begin
			val_s11 <= val_s10 * DW'(es1);
		end
	end

	// ---------------- stage 12: new address ----------------
	logic        v_s12;
	pl_t         pl_s12;
	logic [DW-1:0] val_s12, nph_s12, nth_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		pl_s12  <= pl_s11;
		nph_s12 <= nph_s11;
		nth_s12 <= nth_s11;
		val_s12 <= (pl_s11.act == ACT_DIFF) ? val_s11 : (pl_s11.ad + val_s11);
	end

	// ---------------- stage 13: pack and output register ----------------
	logic  done_s13;
	rsp_t  rsp_s13;
	rsp_t  rsp_nx;
	fld_t  nf;
	assign nf.ph = nph_s12;
	assign nf.th = nth_s12;
	assign nf.ad = val_s12;

	// only the field of the request's action is nonzero
	always_comb begin
		rsp_nx = '0;
		unique case (pl_s12.act)
			ACT_ADD, ACT_SUB: rsp_nx.result_pointer =
				pack(nf, phase_bits_q, thread_bits_q, addr_bits_q, addr_first_q);
			ACT_DIFF: rsp_nx.difference = val_s12;
			ACT_CMP:  rsp_nx.compare_true = pl_s12.cmp;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s13 <= 1'b0;
		end else begin
			done_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s13 <= rsp_nx;
	end

	assign done = done_s13;
	assign rsp  = rsp_s13;

	// every request gives exactly one result
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##141 done) else $error("request produced no result");
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> ##141 !done) else $error("result without a request");
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones({rsp.result_pointer != '0, rsp.difference != '0,
			rsp.compare_true}) <= 1)) else $error("more than one result field set");

endmodule
